FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk, off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition at an edge brings the stated consequence.
`define ASSERT_IMPLIES(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> post) \
		else $error(msg);

`endif

FILE: src/fpp_pkg.sv
`default_nettype none

package fpp_pkg;

	// Width of a residue: every valid candidate is below 2^31.
	localparam int unsigned W = 31;
	localparam int unsigned CNT_W = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_ACCMUL,
		ST_SQUARE,
		ST_EMIT
	} state_t;

	// Request to the modular multiplier: p = (a * b) mod m, with b at most m.
	typedef struct packed {
		logic         start;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] m;
	} mm_req_t;

	typedef struct packed {
		logic         done;
		logic [W-1:0] p;
	} mm_rsp_t;

endpackage

`default_nettype wire

FILE: src/fpp_modmul.sv
`default_nettype none

// Interleaved shift-and-add modular multiplier, one bit of a per cycle.
module fpp_modmul (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fpp_pkg::mm_req_t req,
	output fpp_pkg::mm_rsp_t     rsp
);

	`include "assert_macros.svh"

	logic                        busy_q;
	logic                        done_q;
	logic [fpp_pkg::CNT_W-1:0]   cnt_q;
	logic [fpp_pkg::W-1:0]       a_q;
	logic [fpp_pkg::W-1:0]       b_q;
	logic [fpp_pkg::W-1:0]       m_q;
	logic [fpp_pkg::W-1:0]       p_q;

	logic [fpp_pkg::W:0]         m_ext;
	logic [fpp_pkg::W:0]         dbl;
	logic [fpp_pkg::W:0]         dbl_red;
	logic [fpp_pkg::W:0]         sum;
	logic [fpp_pkg::W:0]         sum_red;

	// Partial result stays below m: double it, reduce, add b if the bit is set, reduce.
	always_comb begin
		m_ext   = {1'b0, m_q};
		dbl     = {p_q, 1'b0};
		dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
		sum     = dbl_red + (a_q[fpp_pkg::W-1] ? {1'b0, b_q} : '0);
		sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			m_q   <= req.m;
			p_q   <= '0;
			cnt_q <= fpp_pkg::CNT_W'(fpp_pkg::W - 1);
		end else if (busy_q) begin
			a_q   <= {a_q[fpp_pkg::W-2:0], 1'b0};
			p_q   <= sum_red[fpp_pkg::W-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;

	`ASSERT_IMPLIES(a_no_restart, req.start, !busy_q, "multiplier started while busy")
	`ASSERT_IMPLIES(a_result_reduced, done_q, (p_q < m_q), "product not reduced below modulus")

endmodule

`default_nettype wire

FILE: src/fermat_probable_prime_test.sv
`default_nettype none

// Channel   Direction  Handshake                  Item contents
// item      in         item_valid / item_stall    candidate, random_word, last_round
// result    out        result_valid / result_stall is_probable_prime
//
// An item with a candidate of at most one runs no multiplication and goes straight to
// the emit state. Otherwise a round runs P + L modular multiplications, where P and L
// are the popcount and the bit length of n-1, and the next item is taken once the round
// has been emitted. The multiplications run on the one shared modular multiplier, which
// retires one bit of its multiplier operand per cycle; the base reduction also runs
// on it. item_stall is high for the whole round. Reset clears the state machine and
// the result valid flag, and sets the running verdict to one.
// A held result stalls the block only when the next last round is ready to emit.
module fermat_probable_prime_test (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic signed [31:0]    candidate,
	input  wire logic [30:0]           random_word,
	input  wire logic                  last_round,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic                       is_probable_prime
);

	`include "assert_macros.svh"

	localparam logic [fpp_pkg::W-1:0] ONE = {{(fpp_pkg::W-1){1'b0}}, 1'b1};

	fpp_pkg::state_t          state_q;
	fpp_pkg::state_t          state_d;
	fpp_pkg::mm_req_t         mm_req;
	fpp_pkg::mm_rsp_t         mm_rsp;

	// Round registers: modulus, remaining exponent, running base and accumulator.
	logic [fpp_pkg::W-1:0]    n_q;
	logic [fpp_pkg::W-1:0]    exp_q;
	logic [fpp_pkg::W-1:0]    base_q;
	logic [fpp_pkg::W-1:0]    acc_q;
	logic                     last_q;
	logic                     pass_q;

	logic                     all_rounds_passed_q;
	logic                     result_valid_q;
	logic                     is_probable_prime_q;

	logic                     cand_ok;
	logic [fpp_pkg::W-1:0]    base_new;
	logic [fpp_pkg::W-1:0]    exp_init;
	logic [fpp_pkg::W-1:0]    exp_shift;
	logic                     acc_last;
	logic                     emit_go;
	logic                     verdict;
	logic                     in_mul;

	// A candidate is tested only when it is positive and above one.
	assign cand_ok   = !candidate[31] && (candidate[30:1] != '0);
	assign base_new  = mm_rsp.p + ONE;
	assign exp_init  = n_q - ONE;
	assign exp_shift = exp_q >> 1;
	// No exponent bits are left above the one just multiplied in.
	assign acc_last  = (exp_q[fpp_pkg::W-1:1] == '0);
	assign verdict   = all_rounds_passed_q & pass_q;
	assign in_mul    = (state_q == fpp_pkg::ST_ACCMUL) || (state_q == fpp_pkg::ST_SQUARE);

	// Sequencer: picks the next multiplication and feeds the shared unit.
	always_comb begin
		state_d      = state_q;
		mm_req.start = 1'b0;
		mm_req.a     = acc_q;
		mm_req.b     = base_q;
		mm_req.m     = n_q;
		emit_go      = 1'b0;
		case (state_q)
			fpp_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (cand_ok) begin
						// Base reduction: random_word * 1 mod (n - 1).
						mm_req.start = 1'b1;
						mm_req.a     = random_word;
						mm_req.b     = ONE;
						mm_req.m     = candidate[fpp_pkg::W-1:0] - ONE;
						state_d      = fpp_pkg::ST_REDUCE;
					end else begin
						state_d = fpp_pkg::ST_EMIT;
					end
				end
			end
			fpp_pkg::ST_REDUCE: begin
				if (mm_rsp.done) begin
					mm_req.start = 1'b1;
					if (exp_init[0]) begin
						mm_req.a = ONE;
						mm_req.b = base_new;
						state_d  = fpp_pkg::ST_ACCMUL;
					end else begin
						mm_req.a = base_new;
						mm_req.b = base_new;
						state_d  = fpp_pkg::ST_SQUARE;
					end
				end
			end
			fpp_pkg::ST_ACCMUL: begin
				if (mm_rsp.done) begin
					if (acc_last) begin
						state_d = fpp_pkg::ST_EMIT;
					end else begin
						mm_req.start = 1'b1;
						mm_req.a     = base_q;
						mm_req.b     = base_q;
						state_d      = fpp_pkg::ST_SQUARE;
					end
				end
			end
			fpp_pkg::ST_SQUARE: begin
				if (mm_rsp.done) begin
					mm_req.start = 1'b1;
					if (exp_shift[0]) begin
						mm_req.a = acc_q;
						mm_req.b = mm_rsp.p;
						state_d  = fpp_pkg::ST_ACCMUL;
					end else begin
						mm_req.a = mm_rsp.p;
						mm_req.b = mm_rsp.p;
						state_d  = fpp_pkg::ST_SQUARE;
					end
				end
			end
			fpp_pkg::ST_EMIT: begin
				// A last round waits only while an earlier verdict is still held.
				if (!last_q || !result_valid_q || !result_stall) begin
					emit_go = 1'b1;
					state_d = fpp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fpp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fpp_pkg::ST_IDLE: begin
				if (item_valid) begin
					n_q    <= candidate[fpp_pkg::W-1:0];
					last_q <= last_round;
					pass_q <= 1'b0;
				end
			end
			fpp_pkg::ST_REDUCE: begin
				if (mm_rsp.done) begin
					base_q <= base_new;
					exp_q  <= exp_init;
					acc_q  <= ONE;
				end
			end
			fpp_pkg::ST_ACCMUL: begin
				if (mm_rsp.done) begin
					acc_q <= mm_rsp.p;
					if (acc_last) begin
						pass_q <= (mm_rsp.p == ONE);
					end
				end
			end
			fpp_pkg::ST_SQUARE: begin
				if (mm_rsp.done) begin
					base_q <= mm_rsp.p;
					exp_q  <= exp_shift;
				end
			end
			default: begin
			end
		endcase
	end

	// Running verdict and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_rounds_passed_q <= 1'b1;
			result_valid_q      <= 1'b0;
		end else begin
			if (emit_go && last_q) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (emit_go) begin
				if (last_q) begin
					all_rounds_passed_q <= 1'b1;
				end else begin
					all_rounds_passed_q <= verdict;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go && last_q) begin
			is_probable_prime_q <= verdict;
		end
	end

	fpp_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	assign item_stall        = (state_q != fpp_pkg::ST_IDLE);
	assign result_valid      = result_valid_q;
	assign is_probable_prime = is_probable_prime_q;

	`ASSERT_IMPLIES(a_operands_reduced, in_mul, (acc_q < n_q && base_q < n_q), "bad operands")
	`ASSERT_IMPLIES(a_verdict_rearm, emit_go && last_q, ##1 all_rounds_passed_q, "no rearm")

endmodule

`default_nettype wire
